// ===== design/wgs_pkg.sv =====
// ============================================================================
// wgs_pkg
// Shared types, field widths, codes and direction helpers of the weighted
// grid step block.
// ============================================================================
package wgs_pkg;

    localparam int CELL_W     = 20;
    localparam int RND_W      = 31;
    localparam int WFLD_W     = 16;
    localparam int ROW_OUT_W  = 10;
    localparam int COL_OUT_W  = 10;
    localparam int CODE_W     = 4;
    localparam int CFG_W      = 11;
    localparam int NUM_DIRS   = 9;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam int IN_CELL_LSB = 0;
    localparam int IN_RND_LSB  = IN_CELL_LSB + CELL_W;
    localparam int IN_W_LSB    = IN_RND_LSB + RND_W;
    localparam int IN_TDATA_W  = ((IN_W_LSB + NUM_DIRS * WFLD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ROW_OUT_W + COL_OUT_W + CELL_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] GRID_ROWS_RST = 11'd64;
    localparam logic [CFG_W-1:0] GRID_COLS_RST = 11'd64;

    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_MOVE  = 1'b1;

    typedef logic [CODE_W-1:0] t_dir;

    localparam t_dir DIR_UL = 4'd0;
    localparam t_dir DIR_U  = 4'd1;
    localparam t_dir DIR_UR = 4'd2;
    localparam t_dir DIR_L  = 4'd3;
    localparam t_dir DIR_S  = 4'd4;
    localparam t_dir DIR_R  = 4'd5;
    localparam t_dir DIR_DL = 4'd6;
    localparam t_dir DIR_D  = 4'd7;
    localparam t_dir DIR_DR = 4'd8;

    localparam logic [CODE_W-1:0] CODE_PLACE = 4'd0;

    typedef struct packed {
        logic capture;
        logic mul_area;
        logic div_start_place;
        logic sum1;
        logic div_start_move;
        logic set_place;
        logic dir_from_rem;
        logic scan;
        logic step;
        logic mul_cell;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic total_zero;
        logic scan_hit;
    } t_dp_stat;

    function automatic logic dir_up(input t_dir d);
        return (d == DIR_UL) || (d == DIR_U) || (d == DIR_UR);
    endfunction

    function automatic logic dir_down(input t_dir d);
        return (d == DIR_DL) || (d == DIR_D) || (d == DIR_DR);
    endfunction

    function automatic logic dir_left(input t_dir d);
        return (d == DIR_UL) || (d == DIR_L) || (d == DIR_DL);
    endfunction

    function automatic logic dir_right(input t_dir d);
        return (d == DIR_UR) || (d == DIR_R) || (d == DIR_DR);
    endfunction

endpackage

// ===== design/wgs_div.sv =====
// ============================================================================
// wgs_div
// Restoring divider that retires one quotient bit per cycle and returns
// both quotient and remainder.
// ============================================================================
module wgs_div #(
    parameter int DVD_W = 31,
    parameter int DVS_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient,
    output logic [DVS_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_fit;

    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_fit   = ~w_diff[DVS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== design/wgs_dp.sv =====
// ============================================================================
// wgs_dp
// Datapath: holds the item and the agent position, sums the weights, runs
// the shared divider, scans the running sums, steps and forms the result.
// ============================================================================
module wgs_dp #(
    parameter int MAX_DIM     = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  wgs_pkg::t_dp_cmd                        i_cmd,
    output wgs_pkg::t_dp_stat                       o_stat,
    input  logic [wgs_pkg::CFG_W-1:0]               i_grid_rows,
    input  logic [wgs_pkg::CFG_W-1:0]               i_grid_cols,
    input  logic [wgs_pkg::CELL_W-1:0]              i_cell_index,
    input  logic [wgs_pkg::RND_W-1:0]               i_random_word,
    input  logic [wgs_pkg::NUM_DIRS-1:0][wgs_pkg::WFLD_W-1:0] i_weights,
    output logic [wgs_pkg::ROW_OUT_W-1:0]           o_new_row,
    output logic [wgs_pkg::COL_OUT_W-1:0]           o_new_col,
    output logic [wgs_pkg::CELL_W-1:0]              o_new_cell,
    output logic [wgs_pkg::CODE_W-1:0]              o_move_code
);

    import wgs_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int DV_W   = $clog2(MAX_DIM + 1);
    localparam int WB_USE = (WEIGHT_BITS < WFLD_W) ? WEIGHT_BITS : WFLD_W;
    localparam int PART_W = WB_USE + 2;
    localparam int SUM_W  = WB_USE + 4;
    localparam int DIV_W  = (SUM_W > DV_W) ? SUM_W : DV_W;
    localparam int PROD_W = 2 * DV_W;
    localparam int CMP_W  = (PROD_W > CELL_W) ? PROD_W : CELL_W;

    function automatic logic [DV_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return DV_W'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            return DV_W'(MAX_DIM);
        end else begin
            return DV_W'(v);
        end
    endfunction

    logic [CELL_W-1:0] r_idx;
    logic [RND_W-1:0]  r_rnd;
    logic [WB_USE-1:0] r_w [NUM_DIRS];
    logic [PART_W-1:0] r_part [3];
    logic [SUM_W-1:0]  r_total;
    logic [SUM_W-1:0]  r_run;
    t_dir              r_dir;
    logic [PROD_W-1:0] r_prod;
    logic [DIM_W-1:0]  r_pos_row;
    logic [DIM_W-1:0]  r_pos_col;
    logic [CODE_W-1:0] r_code;
    logic [ROW_OUT_W-1:0] r_out_row;
    logic [COL_OUT_W-1:0] r_out_col;
    logic [CELL_W-1:0]    r_out_cell;
    logic [CODE_W-1:0]    r_out_code;

    logic [DV_W-1:0]   w_rows;
    logic [DV_W-1:0]   w_cols;
    logic [DV_W-1:0]   w_rows_m1;
    logic [DV_W-1:0]   w_cols_m1;
    logic [DV_W-1:0]   w_mul_a;
    logic [CMP_W-1:0]  w_last_x;
    logic [CMP_W-1:0]  w_idx_x;
    logic [CELL_W-1:0] w_idx_c;
    logic [SUM_W-1:0]  w_total;
    logic              w_div_start;
    logic [RND_W-1:0]  w_dividend;
    logic [DIV_W-1:0]  w_divisor;
    logic              w_div_busy;
    logic              w_div_done;
    logic [RND_W-1:0]  w_quo;
    logic [DIV_W-1:0]  w_rem;
    logic [SUM_W-1:0]  w_run_next;
    logic              w_scan_hit;
    logic [DV_W-1:0]   w_row_c;
    logic [DV_W-1:0]   w_col_c;
    logic [DV_W-1:0]   w_row_n;
    logic [DV_W-1:0]   w_col_n;
    logic [31:0]       w_cell_x;
    logic [31:0]       w_row_x;
    logic [31:0]       w_col_x;

    assign w_rows    = eff_dim(i_grid_rows);
    assign w_cols    = eff_dim(i_grid_cols);
    assign w_rows_m1 = w_rows - DV_W'(1);
    assign w_cols_m1 = w_cols - DV_W'(1);

    assign w_mul_a = i_cmd.mul_area ? w_rows : DV_W'(r_pos_row);

    assign w_last_x = CMP_W'(r_prod) - CMP_W'(1);
    assign w_idx_x  = CMP_W'(r_idx);
    assign w_idx_c  = (w_idx_x > w_last_x) ? w_last_x[CELL_W-1:0] : r_idx;

    assign w_total = SUM_W'(r_part[0]) + SUM_W'(r_part[1]) + SUM_W'(r_part[2]);

    assign w_div_start = i_cmd.div_start_place | i_cmd.div_start_move;
    assign w_dividend  = i_cmd.div_start_place ? RND_W'(w_idx_c) : r_rnd;

    always_comb begin
        if (i_cmd.div_start_place) begin
            w_divisor = DIV_W'(w_cols);
        end else if (w_total == '0) begin
            w_divisor = DIV_W'(NUM_DIRS);
        end else begin
            w_divisor = DIV_W'(w_total);
        end
    end

    wgs_div #(
        .DVD_W(RND_W),
        .DVS_W(DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo),
        .o_remainder(w_rem)
    );

    assign w_run_next = r_run + SUM_W'(r_w[r_dir]);
    assign w_scan_hit = (DIV_W'(w_run_next) > w_rem) || (r_dir == DIR_DR);

    assign w_row_c = (DV_W'(r_pos_row) > w_rows_m1) ? w_rows_m1 : DV_W'(r_pos_row);
    assign w_col_c = (DV_W'(r_pos_col) > w_cols_m1) ? w_cols_m1 : DV_W'(r_pos_col);

    always_comb begin
        if (dir_up(r_dir) && (w_row_c != '0)) begin
            w_row_n = w_row_c - DV_W'(1);
        end else if (dir_down(r_dir) && (w_row_c != w_rows_m1)) begin
            w_row_n = w_row_c + DV_W'(1);
        end else begin
            w_row_n = w_row_c;
        end
        if (dir_left(r_dir) && (w_col_c != '0)) begin
            w_col_n = w_col_c - DV_W'(1);
        end else if (dir_right(r_dir) && (w_col_c != w_cols_m1)) begin
            w_col_n = w_col_c + DV_W'(1);
        end else begin
            w_col_n = w_col_c;
        end
    end

    assign w_cell_x = 32'(r_prod) + 32'(r_pos_col);
    assign w_row_x  = 32'(r_pos_row);
    assign w_col_x  = 32'(r_pos_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_row <= '0;
            r_pos_col <= '0;
        end else if (i_cmd.set_place) begin
            r_pos_row <= w_quo[DIM_W-1:0];
            r_pos_col <= w_rem[DIM_W-1:0];
        end else if (i_cmd.step) begin
            r_pos_row <= w_row_n[DIM_W-1:0];
            r_pos_col <= w_col_n[DIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx  <= i_cell_index;
            r_rnd  <= i_random_word;
            r_code <= CODE_PLACE;
            for (int k = 0; k < NUM_DIRS; k++) begin
                r_w[k] <= i_weights[k][WB_USE-1:0];
            end
        end
        if (i_cmd.mul_area || i_cmd.mul_cell) begin
            r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_cols);
        end
        if (i_cmd.sum1) begin
            for (int k = 0; k < 3; k++) begin
                r_part[k] <= PART_W'(r_w[3*k]) + PART_W'(r_w[3*k+1]) + PART_W'(r_w[3*k+2]);
            end
        end
        if (i_cmd.div_start_move) begin
            r_total <= w_total;
            r_run   <= '0;
            r_dir   <= DIR_UL;
        end
        if (i_cmd.dir_from_rem) begin
            r_dir <= w_rem[CODE_W-1:0];
        end
        if (i_cmd.scan && !w_scan_hit) begin
            r_run <= w_run_next;
            r_dir <= r_dir + CODE_W'(1);
        end
        if (i_cmd.step) begin
            r_code <= CODE_W'(r_dir) + CODE_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out_row  <= w_row_x[ROW_OUT_W-1:0];
            r_out_col  <= w_col_x[COL_OUT_W-1:0];
            r_out_cell <= w_cell_x[CELL_W-1:0];
            r_out_code <= r_code;
        end
    end

    assign o_stat.div_done   = w_div_done;
    assign o_stat.total_zero = (r_total == '0);
    assign o_stat.scan_hit   = w_scan_hit;

    assign o_new_row   = r_out_row;
    assign o_new_col   = r_out_col;
    assign o_new_cell  = r_out_cell;
    assign o_move_code = r_out_code;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("Divider restarted while busy.");

    a_mod9_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dir_from_rem |-> (w_rem < DIV_W'(NUM_DIRS)))
        else $error("Fallback direction out of range.");

    a_run_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (w_run_next <= r_total))
        else $error("Running weight sum exceeds the total.");

    a_pos_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step || i_cmd.set_place) |=>
            ((DV_W'(r_pos_row) < w_rows) && (DV_W'(r_pos_col) < w_cols)))
        else $error("Agent position left the grid.");

endmodule

// ===== design/wgs_ctrl.sv =====
// ============================================================================
// wgs_ctrl
// Controller: sequences place and move commands through the datapath and
// owns the input and output handshakes.
// ============================================================================
module wgs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_in_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wgs_pkg::t_dp_cmd   o_cmd,
    input  wgs_pkg::t_dp_stat  i_stat
);

    import wgs_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_PL_MUL   = 4'd1;
    localparam logic [3:0] ST_PL_CLAMP = 4'd2;
    localparam logic [3:0] ST_MV_SUM1  = 4'd3;
    localparam logic [3:0] ST_MV_SUM2  = 4'd4;
    localparam logic [3:0] ST_DIV      = 4'd5;
    localparam logic [3:0] ST_PL_SET   = 4'd6;
    localparam logic [3:0] ST_MV_MOD9  = 4'd7;
    localparam logic [3:0] ST_MV_SCAN  = 4'd8;
    localparam logic [3:0] ST_MV_STEP  = 4'd9;
    localparam logic [3:0] ST_CELL_MUL = 4'd10;
    localparam logic [3:0] ST_DONE     = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_is_move;
    logic       r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_in_cmd == CMD_MOVE) ? ST_MV_SUM1 : ST_PL_MUL;
                end
            end
            ST_PL_MUL: begin
                o_cmd.mul_area = 1'b1;
                n_state = ST_PL_CLAMP;
            end
            ST_PL_CLAMP: begin
                o_cmd.div_start_place = 1'b1;
                n_state = ST_DIV;
            end
            ST_MV_SUM1: begin
                o_cmd.sum1 = 1'b1;
                n_state = ST_MV_SUM2;
            end
            ST_MV_SUM2: begin
                o_cmd.div_start_move = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    if (!r_is_move) begin
                        n_state = ST_PL_SET;
                    end else if (i_stat.total_zero) begin
                        n_state = ST_MV_MOD9;
                    end else begin
                        n_state = ST_MV_SCAN;
                    end
                end
            end
            ST_PL_SET: begin
                o_cmd.set_place = 1'b1;
                n_state = ST_CELL_MUL;
            end
            ST_MV_MOD9: begin
                o_cmd.dir_from_rem = 1'b1;
                n_state = ST_MV_STEP;
            end
            ST_MV_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_hit) begin
                    n_state = ST_MV_STEP;
                end
            end
            ST_MV_STEP: begin
                o_cmd.step = 1'b1;
                n_state = ST_CELL_MUL;
            end
            ST_CELL_MUL: begin
                o_cmd.mul_cell = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_is_move   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.capture) begin
                r_is_move <= i_in_cmd;
            end
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("Result register overwritten before its beat was taken.");

endmodule

// ===== design/weighted_grid_step.sv =====
// ============================================================================
// weighted_grid_step
// Keeps one agent's row and column on a grid of grid_rows by grid_cols cells.
// A place beat (tuser 0) moves the agent to a row-major cell index, saturated
// to the last cell; a move beat (tuser 1) picks one of nine neighbor
// directions by roulette-wheel selection over the weights (random_word mod
// the weight total, or mod 9 when all weights are zero) and steps one cell,
// clamped at the grid edges. Every beat in gives exactly one beat out. One
// command is worked on at a time; the next is taken once the result sits in
// the output register, even if that beat has not been taken yet. Both kinds
// run through the 31-step shared divider; a move with a nonzero weight total
// then scans up to nine running sums. Registers: grid_rows at address 0,
// grid_cols at address 4.
// ============================================================================
module weighted_grid_step #(
    parameter int MAX_DIM     = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wgs_pkg::APB_AW-1:0]         paddr,
    input  logic [wgs_pkg::APB_DW-1:0]         pwdata,
    output logic [wgs_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cell_index, random_word, weight_up_left .. weight_down_right, zero fill
    input  logic [wgs_pkg::IN_TDATA_W-1:0]     s_tdata,
    // cmd
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // new_row, new_col, new_cell
    output logic [wgs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // move_code
    output logic [wgs_pkg::CODE_W-1:0]         m_tuser
);

    import wgs_pkg::*;

    logic [CFG_W-1:0]     r_grid_rows;
    logic [CFG_W-1:0]     r_grid_cols;
    logic                 w_cfg_wr;
    logic                 w_reg_sel;
    t_dp_cmd              w_cmd;
    t_dp_stat             w_stat;
    logic [ROW_OUT_W-1:0] w_new_row;
    logic [COL_OUT_W-1:0] w_new_col;
    logic [CELL_W-1:0]    w_new_cell;

    assign pready    = 1'b1;
    assign w_reg_sel = paddr[2];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= GRID_ROWS_RST;
            r_grid_cols <= GRID_COLS_RST;
        end else if (w_cfg_wr) begin
            if (w_reg_sel == REG_GRID_ROWS) begin
                r_grid_rows <= pwdata[CFG_W-1:0];
            end else begin
                r_grid_cols <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (w_reg_sel == REG_GRID_ROWS) ? APB_DW'(r_grid_rows) : APB_DW'(r_grid_cols);

    wgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_in_cmd   (s_tuser),
        .o_out_valid(m_tvalid),
        .i_out_ready(m_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    wgs_dp #(
        .MAX_DIM    (MAX_DIM),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_grid_rows  (r_grid_rows),
        .i_grid_cols  (r_grid_cols),
        .i_cell_index (s_tdata[IN_CELL_LSB +: CELL_W]),
        .i_random_word(s_tdata[IN_RND_LSB +: RND_W]),
        .i_weights    (s_tdata[IN_W_LSB +: NUM_DIRS * WFLD_W]),
        .o_new_row    (w_new_row),
        .o_new_col    (w_new_col),
        .o_new_cell   (w_new_cell),
        .o_move_code  (m_tuser)
    );

    assign m_tdata = OUT_TDATA_W'({w_new_cell, w_new_col, w_new_row});

endmodule

// ===== tb/grid_step_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// grid_step_checker
// Watches the register port and both streams of weighted_grid_step, keeps its
// own copy of the grid size and the agent position, and works out the row,
// column, cell and move code for every accepted command. Results are checked
// in order against the oldest expected step.
// ============================================================================
module grid_step_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [wgs_pkg::APB_AW-1:0]       i_paddr,
    input  logic [wgs_pkg::APB_DW-1:0]       i_pwdata,
    input  logic                             i_pready,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // cell_index, random_word, weight_up_left .. weight_down_right, zero fill
    input  logic [wgs_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // cmd
    input  logic                             i_s_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // new_row, new_col, new_cell
    input  logic [wgs_pkg::OUT_TDATA_W-1:0]  i_m_tdata,
    // move_code
    input  logic [wgs_pkg::CODE_W-1:0]       i_m_tuser,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);
    import wgs_pkg::*;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [CELL_W-1:0]    cell_no;
        logic [CODE_W-1:0]    code;
    } t_agent_step;

    t_agent_step      expected_steps[$];
    t_agent_step      got_step;
    t_agent_step      want_step;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    int unsigned      agent_row;
    int unsigned      agent_col;
    int               fail_count;
    int               checked_count;

    function automatic int unsigned usable_extent(input logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > 1024) return 1024;
        return v;
    endfunction

    function automatic t_agent_step predict_step(input logic cmd,
                                                 input logic [IN_TDATA_W-1:0] data);
        int unsigned rows;
        int unsigned cols;
        int unsigned last;
        int unsigned idx;
        int unsigned rnd;
        int unsigned total;
        int unsigned draw;
        int unsigned run;
        int unsigned dir;
        int          r;
        int          c;
        int          i;
        bit          found;
        t_agent_step res;
        rows = usable_extent(rows_reg);
        cols = usable_extent(cols_reg);
        dir  = 0;
        if (cmd == CMD_PLACE) begin
            idx  = data[IN_CELL_LSB +: CELL_W];
            last = rows * cols - 1;
            if (idx > last) idx = last;
            agent_row = idx / cols;
            agent_col = idx % cols;
            res.code  = CODE_PLACE;
        end else begin
            rnd   = data[IN_RND_LSB +: RND_W];
            total = 0;
            for (i = 0; i < NUM_DIRS; i++) begin
                total += data[IN_W_LSB + i * WFLD_W +: WFLD_W];
            end
            if (total != 0) begin
                draw  = rnd % total;
                run   = 0;
                found = 1'b0;
                for (i = 0; i < NUM_DIRS; i++) begin
                    run += data[IN_W_LSB + i * WFLD_W +: WFLD_W];
                    if (!found && run > draw) begin
                        dir   = i;
                        found = 1'b1;
                    end
                end
            end else begin
                dir = rnd % NUM_DIRS;
            end
            if (agent_row > rows - 1) agent_row = rows - 1;
            if (agent_col > cols - 1) agent_col = cols - 1;
            r = int'(agent_row) + int'(dir / 3) - 1;
            c = int'(agent_col) + int'(dir % 3) - 1;
            if (r < 0) r = 0;
            if (c < 0) c = 0;
            if (r > int'(rows) - 1) r = int'(rows) - 1;
            if (c > int'(cols) - 1) c = int'(cols) - 1;
            agent_row = r;
            agent_col = c;
            res.code  = CODE_W'(dir + 1);
        end
        res.row     = ROW_OUT_W'(agent_row);
        res.col     = COL_OUT_W'(agent_col);
        res.cell_no = CELL_W'(agent_row * cols + agent_col);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg      = GRID_ROWS_RST;
            cols_reg      = GRID_COLS_RST;
            agent_row     = 0;
            agent_col     = 0;
            fail_count    = 0;
            checked_count = 0;
            expected_steps.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[APB_AW-1:2] == REG_GRID_ROWS) rows_reg = i_pwdata[CFG_W-1:0];
                else cols_reg = i_pwdata[CFG_W-1:0];
            end
            if (i_m_tvalid && i_m_tready) begin
                got_step.row     = i_m_tdata[0 +: ROW_OUT_W];
                got_step.col     = i_m_tdata[ROW_OUT_W +: COL_OUT_W];
                got_step.cell_no = i_m_tdata[ROW_OUT_W + COL_OUT_W +: CELL_W];
                got_step.code    = i_m_tuser;
                checked_count++;
                if (expected_steps.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected result beat row %0d col %0d cell %0d code %0d",
                                 $realtime, got_step.row, got_step.col, got_step.cell_no,
                                 got_step.code);
                    end
                end else begin
                    want_step = expected_steps.pop_front();
                    if (got_step.row !== want_step.row || got_step.col !== want_step.col ||
                        got_step.cell_no !== want_step.cell_no ||
                        got_step.code !== want_step.code)
                    begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: result %0d expected row %0d col %0d cell %0d code %0d",
                                     $realtime, checked_count, want_step.row, want_step.col,
                                     want_step.cell_no, want_step.code);
                            $display("%0t: result %0d actual   row %0d col %0d cell %0d code %0d",
                                     $realtime, checked_count, got_step.row, got_step.col,
                                     got_step.cell_no, got_step.code);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_steps.push_back(predict_step(i_s_tuser, i_s_tdata));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_steps.size();
        o_checked    <= checked_count;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Drives weighted_grid_step with place and move commands over a series of
// grid sizes, including zero and oversized register values, with random gaps
// on the input stream and random back-pressure on the output stream. The
// checker beside the block predicts every result and counts mismatches.
// ============================================================================
module tb;
    import wgs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 93;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [CODE_W-1:0]      m_tuser;
    logic                   no_idle  = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int place_count = 0;
    int move_count  = 0;
    int grid_settings = 1;
    int cfg_rows = 64;
    int cfg_cols = 64;

    weighted_grid_step i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    grid_step_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.", pending);
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 16);
    end

    function automatic int usable_extent(input int v);
        if (v == 0) return 1;
        if (v > 1024) return 1024;
        return v;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_item(input logic [CELL_W-1:0] cell_no,
                                                        input logic [RND_W-1:0] rnd,
                                                        input logic [NUM_DIRS*WFLD_W-1:0] wts);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[IN_CELL_LSB +: CELL_W]          = cell_no;
        d[IN_RND_LSB +: RND_W]            = rnd;
        d[IN_W_LSB +: NUM_DIRS * WFLD_W]  = wts;
        return d;
    endfunction

    function automatic logic [NUM_DIRS*WFLD_W-1:0] single_weight(input int dir,
                                                                input logic [WFLD_W-1:0] w);
        logic [NUM_DIRS*WFLD_W-1:0] wts;
        wts = '0;
        wts[dir * WFLD_W +: WFLD_W] = w;
        return wts;
    endfunction

    function automatic logic [NUM_DIRS*WFLD_W-1:0] random_weights();
        logic [NUM_DIRS*WFLD_W-1:0] wts;
        int mode;
        int pick;
        int i;
        mode = $urandom_range(9);
        pick = $urandom_range(NUM_DIRS - 1);
        wts  = '0;
        for (i = 0; i < NUM_DIRS; i++) begin
            case (mode)
                4, 5:    wts[i * WFLD_W +: WFLD_W] = $urandom_range(1) ? WFLD_W'($urandom) : '0;
                6:       wts[i * WFLD_W +: WFLD_W] =
                             (i == pick) ? WFLD_W'($urandom_range(1, 65535)) : '0;
                7:       wts[i * WFLD_W +: WFLD_W] = '0;
                8:       wts[i * WFLD_W +: WFLD_W] = WFLD_W'($urandom_range(3));
                9:       wts[i * WFLD_W +: WFLD_W] = '1;
                default: wts[i * WFLD_W +: WFLD_W] = WFLD_W'($urandom);
            endcase
        end
        return wts;
    endfunction

    task automatic send_item(input logic cmd, input logic [IN_TDATA_W-1:0] data);
        while (!no_idle && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        if (cmd == CMD_PLACE) place_count++;
        else move_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_grid_reg(input logic reg_idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_grid(input int rows, input int cols);
        drain();
        write_grid_reg(REG_GRID_ROWS, rows);
        write_grid_reg(REG_GRID_COLS, cols);
        cfg_rows = rows;
        cfg_cols = cols;
        grid_settings++;
    endtask

    task automatic send_random();
        logic                       cmd;
        logic [CELL_W-1:0]          cell_no;
        logic [RND_W-1:0]           rnd;
        int                         area;
        int                         eff_c;
        eff_c = usable_extent(cfg_cols);
        area  = usable_extent(cfg_rows) * eff_c;
        cmd   = ($urandom_range(99) < 25) ? CMD_PLACE : CMD_MOVE;
        case ($urandom_range(3))
            0:       cell_no = CELL_W'($urandom);
            1:       cell_no = CELL_W'($urandom_range(0, area - 1));
            2:       cell_no = CELL_W'(area - 1 + $urandom_range(0, 2));
            default: cell_no = CELL_W'($urandom_range(0, 3 * eff_c));
        endcase
        case ($urandom_range(9))
            0:       rnd = '0;
            1:       rnd = '1;
            default: rnd = RND_W'($urandom);
        endcase
        send_item(cmd, pack_item(cell_no, rnd, random_weights()));
    endtask

    initial begin
        logic [NUM_DIRS*WFLD_W-1:0] wts;
        int phase_rows [NUM_PHASES];
        int phase_cols [NUM_PHASES];
        int p;
        int n;
        int k;
        phase_rows = '{1024, 1, 1024, 3, 2047, 1, 64, -1, -1, -1};
        phase_cols = '{1024, 1024, 1, 5, 0, 1, 64, -1, -1, -1};
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_PLACE;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part on the reset grid of 64 by 64.
        send_item(CMD_PLACE, pack_item('0, '0, '0));
        send_item(CMD_MOVE, pack_item('0, '1, single_weight(0, '1)));
        send_item(CMD_PLACE, pack_item('1, '0, '0));
        send_item(CMD_MOVE, pack_item('0, '0, single_weight(8, 16'd1)));
        send_item(CMD_PLACE, pack_item(20'd2080, '0, '0));
        for (k = 0; k < NUM_DIRS; k++) begin
            send_item(CMD_MOVE, pack_item('0, RND_W'($urandom),
                                          single_weight(k, (k % 2) ? 16'hFFFF : 16'd1)));
        end
        send_item(CMD_MOVE, pack_item('0, '0, '0));
        send_item(CMD_MOVE, pack_item('0, '1, '0));
        send_item(CMD_MOVE, pack_item('0, '1, '1));
        wts = '0;
        for (k = 1; k < NUM_DIRS; k += 2) begin
            wts[k * WFLD_W +: WFLD_W] = WFLD_W'($urandom_range(1, 65535));
        end
        send_item(CMD_MOVE, pack_item('0, RND_W'($urandom), wts));
        wts = '0;
        wts[0 +: WFLD_W]          = 16'd5;
        wts[2 * WFLD_W +: WFLD_W] = 16'd3;
        send_item(CMD_MOVE, pack_item('0, 31'd5, wts));
        send_item(CMD_MOVE, pack_item('0, 31'd4, wts));
        send_item(CMD_PLACE, pack_item(20'd4096, '0, '0));

        // The agent now sits in the far corner; shrinking the grid leaves it outside.
        set_grid(8, 8);
        send_item(CMD_MOVE, pack_item('0, RND_W'($urandom), random_weights()));
        set_grid(0, 0);
        send_item(CMD_PLACE, pack_item(CELL_W'($urandom), '0, '0));
        send_item(CMD_MOVE, pack_item('0, RND_W'($urandom), '1));
        set_grid(2047, 2047);
        send_item(CMD_PLACE, pack_item('1, '0, '0));
        send_item(CMD_MOVE, pack_item('0, RND_W'($urandom), random_weights()));

        for (p = 0; p < NUM_PHASES; p++) begin
            set_grid(phase_rows[p] < 0 ? $urandom_range(0, 1100) : phase_rows[p],
                     phase_cols[p] < 0 ? $urandom_range(0, 1100) : phase_cols[p]);
            no_idle <= (p == 3);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == PHASE_ITEMS / 2) drain();
                send_random();
            end
        end

        no_idle <= 1'b0;
        drain();
        repeat (60) @(negedge i_clk);
        $display("Sent %0d place and %0d move commands over %0d grid settings.",
                 place_count, move_count, grid_settings);
        $display("Checked %0d result beats, %0d with errors, %0d still outstanding.",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== weighted_grid_step.f =====
design/wgs_pkg.sv
design/wgs_div.sv
design/wgs_dp.sv
design/wgs_ctrl.sv
design/weighted_grid_step.sv
tb/grid_step_checker.sv
tb/tb.sv
